// ===== rtl/core/sequential_read_detector_core_macros.svh =====
// assertion shorthands for the detector top level
`ifndef SEQUENTIAL_READ_DETECTOR_CORE_MACROS_SVH
`define SEQUENTIAL_READ_DETECTOR_CORE_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/srd_pkg.sv =====
package srd_pkg;

  // item and register field widths
  localparam int unsigned ID_W     = 32;
  localparam int unsigned PAGE_W   = 48;
  localparam int unsigned OFF_W    = 20;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned LINE_W   = 21;
  localparam int unsigned SPS_W    = 25;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned BYTE_W   = 48;

  // derived datapath widths
  localparam int unsigned ADD_W     = 25;                  // offset + length
  localparam int unsigned DIFF_W    = PAGE_W + 1;          // signed page difference
  localparam int unsigned REM_W     = ADD_W + 1;           // signed byte remainder
  localparam int unsigned PLO_W     = 24;                  // low slice of page difference
  localparam int unsigned PHI_W     = DIFF_W - PLO_W;      // signed high slice
  localparam int unsigned PROD_LO_W = PLO_W + LINE_W;
  localparam int unsigned PROD_HI_W = PHI_W + LINE_W + 1;
  localparam int unsigned SPAN_W    = PROD_HI_W + PLO_W;
  localparam int unsigned THR_W     = RATIO_W + SPS_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [LINE_W-1:0]  LINE_SIZE_RST = LINE_W'(4096);
  localparam logic [SPS_W-1:0]   SPS_RST       = SPS_W'(16384);
  localparam logic [CNT_W-1:0]   PF_COUNT_RST  = CNT_W'(1);
  localparam logic [RATIO_W-1:0] PF_RATIO_RST  = RATIO_W'(128);
  localparam logic [THR_W-1:0]   THR_RST       = THR_W'(128 * 16384);

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_SIZE = CFG_IDX_W'(0),
    CFG_SPS       = CFG_IDX_W'(1),
    CFG_PF_COUNT  = CFG_IDX_W'(2),
    CFG_PF_RATIO  = CFG_IDX_W'(3)
  } cfg_idx_e;

  // what the front decided about an item
  typedef enum logic [1:0] {
    KIND_CONT,
    KIND_SEQ,
    KIND_BREAK
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADD_W-1:0]  prev_add;
  } entry_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_size;
    logic [CNT_W-1:0]  pf_count;
    logic [THR_W-1:0]  threshold;
  } cfg_t;

  typedef struct packed {
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

endpackage

// ===== rtl/core/srd_cfg.sv =====
module srd_cfg import srd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [LINE_W-1:0]  line_q;
  logic [SPS_W-1:0]   sps_q;
  logic [CNT_W-1:0]   count_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [THR_W-1:0]   thr_q, thr_d;

  // ratio * super page size, kept registered for the back compare
  assign thr_d = THR_W'(ratio_q) * THR_W'(sps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= LINE_SIZE_RST;
      sps_q   <= SPS_RST;
      count_q <= PF_COUNT_RST;
      ratio_q <= PF_RATIO_RST;
      thr_q   <= THR_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LINE_SIZE: line_q  <= cfg_data_i[LINE_W-1:0];
          CFG_SPS:       sps_q   <= cfg_data_i[SPS_W-1:0];
          CFG_PF_COUNT:  count_q <= cfg_data_i[CNT_W-1:0];
          CFG_PF_RATIO:  ratio_q <= cfg_data_i[RATIO_W-1:0];
          default: begin
          end
        endcase
      end
      thr_q <= thr_d;
    end
  end

  assign cfg_o.line_size = line_q;
  assign cfg_o.pf_count  = count_q;
  assign cfg_o.threshold = thr_q;

endmodule

// ===== rtl/core/srd_front.sv =====
module srd_front import srd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [ID_W-1:0]   req_id_i,
  input  logic [PAGE_W-1:0] start_page_i,
  input  logic [OFF_W-1:0]  req_offset_i,
  input  logic [LEN_W-1:0]  req_length_i,
  input  logic [LINE_W-1:0] line_size_i,
  output logic              push_o,
  output entry_t            entry_o
);

  // copy of the stored request; it is always the previous item
  logic [ID_W-1:0]   last_id_q;
  logic [PAGE_W-1:0] prev_page_q;
  logic [ADD_W-1:0]  prev_add_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q;

  logic              s1_same_q;
  logic [DIFF_W-1:0] s1_diff_q;
  logic [REM_W-1:0]  s1_rem_q;
  logic [ADD_W-1:0]  s1_padd_q;

  logic                 s2_same_q;
  logic [PROD_HI_W-1:0] s2_phi_q;
  logic [PROD_LO_W-1:0] s2_plo_q;
  logic [REM_W-1:0]     s2_rem_q;
  logic [ADD_W-1:0]     s2_padd_q;

  kind_e            s3_kind_q;
  logic [ADD_W-1:0] s3_padd_q;

  logic                        same_d;
  logic [DIFF_W-1:0]           diff_d;
  logic [REM_W-1:0]            rem_d;
  logic [ADD_W-1:0]            add_d;
  logic signed [PROD_HI_W-1:0] phi_d;
  logic [PROD_LO_W-1:0]        plo_d;
  logic [SPAN_W-1:0]           span_d;
  logic [SPAN_W-1:0]           rem_ext_d;
  kind_e                       kind_d;

  // contiguous when (page - prev_page) * line_size == prev_add - offset
  assign same_d = (req_id_i == last_id_q);
  assign diff_d = {1'b0, start_page_i} - {1'b0, prev_page_q};
  assign rem_d  = REM_W'(prev_add_q) - REM_W'(req_offset_i);
  assign add_d  = ADD_W'(req_offset_i) + ADD_W'(req_length_i);

  assign phi_d = $signed(s1_diff_q[DIFF_W-1:PLO_W]) * $signed({1'b0, line_size_i});
  assign plo_d = PROD_LO_W'(s1_diff_q[PLO_W-1:0]) * PROD_LO_W'(line_size_i);

  assign span_d    = {s2_phi_q, {PLO_W{1'b0}}} + SPAN_W'(s2_plo_q);
  assign rem_ext_d = {{(SPAN_W-REM_W){s2_rem_q[REM_W-1]}}, s2_rem_q};

  always_comb begin
    if (s2_same_q) begin
      kind_d = KIND_CONT;
    end else if (span_d == rem_ext_d) begin
      kind_d = KIND_SEQ;
    end else begin
      kind_d = KIND_BREAK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_id_q   <= '0;
      prev_page_q <= '0;
      prev_add_q  <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
    end else begin
      if (acc_i) begin
        if (!same_d) begin
          last_id_q <= req_id_i;
        end
        prev_page_q <= start_page_i;
        prev_add_q  <= add_d;
      end
      s1_valid_q <= acc_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_same_q <= same_d;
    s1_diff_q <= diff_d;
    s1_rem_q  <= rem_d;
    s1_padd_q <= prev_add_q;

    s2_same_q <= s1_same_q;
    s2_phi_q  <= phi_d;
    s2_plo_q  <= plo_d;
    s2_rem_q  <= s1_rem_q;
    s2_padd_q <= s1_padd_q;

    s3_kind_q <= kind_d;
    s3_padd_q <= s2_padd_q;
  end

  assign push_o         = s3_valid_q;
  assign entry_o.kind     = s3_kind_q;
  assign entry_o.prev_add = s3_padd_q;

endmodule

// ===== rtl/core/srd_fifo.sv =====
module srd_fifo import srd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     entry_i,
  input  logic       pop_i,
  output entry_t     entry_o,
  output fifo_stat_t stat_o
);

  entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + FIFO_AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FIFO_CW'(1);
        2'b01:   count_q <= count_q - FIFO_CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

// ===== rtl/core/srd_back.sv =====
module srd_back import srd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_empty_i,
  input  entry_t           entry_i,
  input  logic [CNT_W-1:0] pf_count_i,
  input  logic [THR_W-1:0] threshold_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             readahead_on_o,
  output logic             contiguous_o
);

  logic              mode_q, mode_d;
  logic [CNT_W-1:0]  hit_q, hit_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              out_valid_q, out_valid_d;
  logic              ra_q, contig_q, contig_d;

  logic [CNT_W-1:0]    hit_inc;
  logic [BYTE_W:0]     byte_sum;
  logic [BYTE_W-1:0]   byte_inc;
  logic                enable;

  assign pop_o = !fifo_empty_i && (!out_valid_q || out_ready_i);

  // saturating counters
  assign hit_inc  = (hit_q == '1) ? hit_q : hit_q + CNT_W'(1);
  assign byte_sum = {1'b0, byte_q} + (BYTE_W + 1)'(entry_i.prev_add);
  assign byte_inc = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
  // bytes * 256 against ratio * super page size
  assign enable   = (hit_inc >= pf_count_i) &&
                    ({byte_inc, 8'b0} >= (BYTE_W + 8)'(threshold_i));

  always_comb begin
    mode_d   = mode_q;
    hit_d    = hit_q;
    byte_d   = byte_q;
    contig_d = 1'b0;
    case (entry_i.kind)
      KIND_CONT: begin
      end
      KIND_SEQ: begin
        contig_d = 1'b1;
        if (!mode_q) begin
          hit_d  = hit_inc;
          byte_d = byte_inc;
          mode_d = enable;
        end
      end
      KIND_BREAK: begin
        mode_d = 1'b0;
        hit_d  = '0;
        byte_d = '0;
      end
      default: begin
      end
    endcase

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      hit_q       <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q <= mode_d;
        hit_q  <= hit_d;
        byte_q <= byte_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ra_q     <= mode_d;
      contig_q <= contig_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign readahead_on_o = ra_q;
  assign contiguous_o   = contig_q;

endmodule

// ===== rtl/core/sequential_read_detector_core.sv =====
// path: an item passes 3 front stages, the queue and the result register before its result is valid
// throughput: one item per cycle while input ready holds; the 8-entry queue and result register
// absorb output stalls; input ready drops once 8 items sit between acceptance and the back end
// reset: asynchronous, clears the stored request, mode and both counters, loads register defaults
// no clearing pass after reset; items are taken as soon as reset is released
`include "sequential_read_detector_core_macros.svh"

module sequential_read_detector_core import srd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ID_W-1:0]       req_id_i,
  input  logic [PAGE_W-1:0]     start_page_i,
  input  logic [OFF_W-1:0]      req_offset_i,
  input  logic [LEN_W-1:0]      req_length_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  readahead_on_o,
  output logic                  contiguous_o
);

  cfg_t               cfg;
  logic               in_acc;
  logic               front_push;
  entry_t             front_entry;
  entry_t             head_entry;
  fifo_stat_t         fifo_stat;
  logic               back_pop;
  logic [FIFO_CW-1:0] occ_q, occ_d;

  assign cfg_ready_o = 1'b1;

  // items accepted but not yet handed to the back end
  assign in_ready_o = (occ_q < FIFO_CW'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    case ({in_acc, back_pop})
      2'b10:   occ_d = occ_q + FIFO_CW'(1);
      2'b01:   occ_d = occ_q - FIFO_CW'(1);
      default: occ_d = occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  srd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  srd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .req_id_i     (req_id_i),
    .start_page_i (start_page_i),
    .req_offset_i (req_offset_i),
    .req_length_i (req_length_i),
    .line_size_i  (cfg.line_size),
    .push_o       (front_push),
    .entry_o      (front_entry)
  );

  srd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .entry_i (front_entry),
    .pop_i   (back_pop),
    .entry_o (head_entry),
    .stat_o  (fifo_stat)
  );

  srd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (fifo_stat.empty),
    .entry_i        (head_entry),
    .pf_count_i     (cfg.pf_count),
    .threshold_i    (cfg.threshold),
    .pop_o          (back_pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .readahead_on_o (readahead_on_o),
    .contiguous_o   (contiguous_o)
  );

  `SRD_ASSERT(a_occ_bound, occ_q <= FIFO_CW'(FIFO_DEPTH), "in-flight count above queue depth")
  `SRD_ASSERT(a_queue_within_credit, fifo_stat.count <= occ_q, "queue holds more than accepted")
  `SRD_ASSERT_IMP(a_pop_nonempty, back_pop, !fifo_stat.empty, "back end popped an empty queue")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import srd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MID = CFG_IDX_W'(8);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_TOP = CFG_IDX_W'(12);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = CFG_IDX_W'(15);

  localparam logic [PAGE_W-1:0] PAGE_MAX  = {PAGE_W{1'b1}};
  localparam logic [OFF_W-1:0]  OFF_MAX   = {OFF_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [ID_W-1:0]   ID_MAX    = {ID_W{1'b1}};
  localparam logic [BYTE_W:0]   BYTE_CAP  = {1'b0, {BYTE_W{1'b1}}};
  localparam logic [71:0]       OFF_LIM   = 72'(OFF_MAX);
  localparam logic [71:0]       PAGE_LIM  = 72'(PAGE_MAX);
  // 128000 bytes per request: the byte condition holds well before the hit count does
  localparam logic [LEN_W-1:0]  CHAIN_LEN = LEN_W'(128000);
  localparam int unsigned       CHAIN_ITEMS = 130;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
  } req_t;

  typedef struct packed {
    logic ra;
    logic contig;
  } verdict_t;

  typedef struct packed {
    logic     typed;
    verdict_t v;
  } literal_t;

  typedef struct packed {
    req_t     req;
    literal_t lit;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ID_W-1:0]       req_id_i;
  logic [PAGE_W-1:0]     start_page_i;
  logic [OFF_W-1:0]      req_offset_i;
  logic [LEN_W-1:0]      req_length_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  readahead_on_o;
  logic                  contiguous_o;

  sequential_read_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_id_i      (req_id_i),
    .start_page_i  (start_page_i),
    .req_offset_i  (req_offset_i),
    .req_length_i  (req_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .readahead_on_o(readahead_on_o),
    .contiguous_o  (contiguous_o)
  );

  // detector copy: registers and stored request
  logic [LINE_W-1:0]  reg_line;
  logic [SPS_W-1:0]   reg_sps;
  logic [CNT_W-1:0]   reg_count;
  logic [RATIO_W-1:0] reg_ratio;
  logic [ID_W-1:0]    det_id;
  logic [PAGE_W-1:0]  det_page;
  logic [OFF_W-1:0]   det_off;
  logic [LEN_W-1:0]   det_len;
  logic               det_mode;
  logic [CNT_W-1:0]   det_hits;
  logic [BYTE_W-1:0]  det_bytes;

  verdict_t verdict_q[$];
  literal_t literal_q[$];
  row_t     plan[$];
  req_t     gen_last;

  int  items_sent;
  int  results_seen;
  int  mismatches;
  bit  calm;
  bit  hold_armed;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("sequential_read_detector_core verification failed");
    $finish;
  end

  function automatic verdict_t advance_detector(input req_t r);
    logic [71:0]       end_b;
    logic [71:0]       start_b;
    logic [ADD_W-1:0]  add;
    logic [BYTE_W:0]   sum;
    logic [63:0]       thr;
    logic [63:0]       scaled;
    verdict_t          v;
    v.contig = 1'b0;
    if (r.id != det_id) begin
      add = ADD_W'(det_off) + ADD_W'(det_len);
      end_b = 72'(det_page) * 72'(reg_line) + 72'(add);
      start_b = 72'(r.page) * 72'(reg_line) + 72'(r.off);
      v.contig = (end_b == start_b);
      if (v.contig) begin
        if (!det_mode) begin
          if (det_hits != {CNT_W{1'b1}}) det_hits = det_hits + 1'b1;
          sum = {1'b0, det_bytes} + (BYTE_W + 1)'(add);
          det_bytes = (sum > BYTE_CAP) ? BYTE_CAP[BYTE_W-1:0] : sum[BYTE_W-1:0];
          thr = 64'(reg_ratio) * 64'(reg_sps);
          scaled = {det_bytes, 8'h00};
          if (det_hits >= reg_count && scaled >= thr) det_mode = 1'b1;
        end
      end else begin
        det_mode = 1'b0;
        det_hits = '0;
        det_bytes = '0;
      end
      det_id = r.id;
    end
    det_page = r.page;
    det_off = r.off;
    det_len = r.len;
    v.ra = det_mode;
    return v;
  endfunction

  task automatic compare_bit(input string fld, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at result %0d: expected %0b, got %0b",
                 fld, results_seen, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    verdict_t want;
    literal_t lit;
    req_t     r;
    if (!rst_ni) begin
      reg_line = LINE_SIZE_RST;
      reg_sps = SPS_RST;
      reg_count = PF_COUNT_RST;
      reg_ratio = PF_RATIO_RST;
      det_id = '0;
      det_page = '0;
      det_off = '0;
      det_len = '0;
      det_mode = 1'b0;
      det_hits = '0;
      det_bytes = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LINE_SIZE: reg_line = cfg_data_i[LINE_W-1:0];
          CFG_SPS:       reg_sps = cfg_data_i[SPS_W-1:0];
          CFG_PF_COUNT:  reg_count = cfg_data_i[CNT_W-1:0];
          CFG_PF_RATIO:  reg_ratio = cfg_data_i[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing pending: readahead_on %0b contiguous %0b",
                     readahead_on_o, contiguous_o);
        end else begin
          want = verdict_q.pop_front();
          lit = '0;
          if (literal_q.size() != 0) lit = literal_q.pop_front();
          results_seen++;
          compare_bit("readahead_on", want.ra, readahead_on_o);
          compare_bit("contiguous", want.contig, contiguous_o);
          if (lit.typed) begin
            compare_bit("readahead_on (table)", lit.v.ra, readahead_on_o);
            compare_bit("contiguous (table)", lit.v.contig, contiguous_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        r = '{req_id_i, start_page_i, req_offset_i, req_length_i};
        verdict_q = {verdict_q, advance_detector(r)};
      end
    end
  end

  // sink side: random backpressure (always ready while calm), one long hold-off when armed
  initial begin : sink
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed && hold_left == 0) begin
        hold_armed = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic logic [LEN_W-1:0] pick_len();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return LEN_MAX;
    if (sel < 4) return LEN_W'($urandom);
    return LEN_W'($urandom_range(20000));
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.id = $urandom;
    if ($urandom_range(1) == 1) r.page = PAGE_W'({$urandom, $urandom});
    else r.page = gen_last.page + PAGE_W'($urandom_range(2));
    r.off = OFF_W'($urandom);
    r.len = pick_len();
    return r;
  endfunction

  // successor starting at the stored end byte; falls back to noise when unreachable
  function automatic req_t follow_on(input logic [LEN_W-1:0] len);
    logic [71:0] end_b;
    logic [71:0] q;
    logic [71:0] rem;
    req_t        r;
    r = noise_req();
    r.len = len;
    if (r.id == gen_last.id) r.id = r.id + 1'b1;
    end_b = 72'(gen_last.page) * 72'(reg_line) + 72'(gen_last.off) + 72'(gen_last.len);
    if (reg_line == '0) begin
      if (end_b <= OFF_LIM) r.off = end_b[OFF_W-1:0];
    end else begin
      q = end_b / 72'(reg_line);
      rem = end_b % 72'(reg_line);
      if (rem <= OFF_LIM && q <= PAGE_LIM) begin
        r.page = q[PAGE_W-1:0];
        r.off = rem[OFF_W-1:0];
        // offset past the line boundary, one page earlier
        if (q != '0 && rem + 72'(reg_line) <= OFF_LIM && $urandom_range(1) == 1) begin
          r.page = r.page - 1'b1;
          r.off = r.off + OFF_W'(reg_line);
        end
      end
    end
    return r;
  endfunction

  task automatic push_item(input req_t r, input literal_t lit);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_id_i <= r.id;
    start_page_i <= r.page;
    req_offset_i <= r.off;
    req_length_i <= r.len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    literal_q = {literal_q, lit};
    gen_last = r;
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] line, input logic [CFG_DATA_W-1:0] sps,
                               input logic [CFG_DATA_W-1:0] cnt, input logic [CFG_DATA_W-1:0] ratio,
                               input logic [CFG_IDX_W-1:0] spare);
    in_valid_i <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    cfg_beat(spare, $urandom);
    cfg_beat(CFG_LINE_SIZE, line);
    cfg_beat(CFG_SPS, sps);
    cfg_beat(CFG_PF_COUNT, cnt);
    cfg_beat(CFG_PF_RATIO, ratio);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int   sel;
    req_t r;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        r = follow_on(pick_len());
      end else if (sel < 77) begin
        r = noise_req();
        r.id = gen_last.id;
      end else begin
        r = noise_req();
      end
      push_item(r, '0);
    end
  endtask

  task automatic add_row(input logic [ID_W-1:0] id, input logic [PAGE_W-1:0] page,
                         input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len,
                         input logic typed, input logic ra, input logic contig);
    row_t row;
    row.req = '{id, page, off, len};
    row.lit = '{typed, '{ra, contig}};
    plan = {plan, row};
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_id_i = '0;
    start_page_i = '0;
    req_offset_i = '0;
    req_length_i = '0;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    calm = 1'b0;
    hold_armed = 1'b0;
    gen_last = '0;

    // stored id is zero out of reset, so id 0 continues it
    add_row(32'd0, 48'd5, 20'd7, 24'd100, 1'b1, 1'b0, 1'b0);
    add_row(32'd1, 48'd5, 20'd107, 24'd8000, 1'b0, 1'b0, 1'b0);
    add_row(32'd2, 48'd6, 20'd4011, 24'd4096, 1'b0, 1'b0, 1'b0);
    add_row(32'd2, 48'd100, 20'd0, 24'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd3, 48'd100, 20'd0, 24'd5, 1'b0, 1'b0, 1'b0);
    add_row(32'd4, 48'd0, 20'd0, 24'd0, 1'b1, 1'b0, 1'b0);
    add_row(ID_MAX, PAGE_MAX, OFF_MAX, LEN_MAX, 1'b1, 1'b0, 1'b0);
    add_row(32'd0, PAGE_MAX, OFF_MAX, 24'd0, 1'b1, 1'b0, 1'b0);
    add_row(32'd5, PAGE_MAX - 1'b1, 20'd0, 24'd4096, 1'b1, 1'b0, 1'b0);
    add_row(32'd6, PAGE_MAX, 20'd0, 24'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd8, 48'd10, 20'd0, 24'd10, 1'b1, 1'b0, 1'b0);
    // offset larger than a line lands on the same byte
    add_row(32'd9, 48'd9, 20'd4106, 24'd1, 1'b0, 1'b0, 1'b0);
    add_row(32'd9, 48'd0, 20'd0, 24'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd10, 48'd0, 20'd0, 24'd9000, 1'b0, 1'b0, 1'b0);
    add_row(32'd11, 48'd2, 20'd808, 24'd1, 1'b0, 1'b0, 1'b0);
    add_row(32'd12, 48'd2, 20'd809, 24'd0, 1'b0, 1'b0, 1'b0);
    add_row(32'd12, 48'd3, 20'd1, 24'd2, 1'b0, 1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) push_item(plan[i].req, plan[i].lit);

    apply_setting(32'd512, 32'd4096, 32'd3, 32'd256, CFG_SPARE_LO);
    hold_armed = 1'b1;
    run_random(350);

    // all-ones data, masked to register widths
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CFG_SPARE_HI);
    run_random(300);

    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, CFG_SPARE_MID);
    run_random(250);

    apply_setting(32'd1, 32'd1, 32'd1, 32'd1, CFG_SPARE_TOP);
    run_random(250);

    // long unbroken chain: the hit count sets where read-ahead turns on
    apply_setting(32'd4096, 32'd8_000_000, 32'd100, 32'd256, CFG_SPARE_LO);
    calm = 1'b1;
    push_item('{$urandom, 48'd0, 20'd0, 24'd0}, '0);
    repeat (CHAIN_ITEMS) push_item(follow_on(CHAIN_LEN), '0);
    calm = 1'b0;

    apply_setting(32'd4096, 32'd16384, 32'd2, 32'hABCD_0080, CFG_SPARE_HI);
    run_random(400);

    in_valid_i <= 1'b0;
    while (results_seen < items_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      mismatches += verdict_q.size();
      $display("%0d predicted results never arrived", verdict_q.size());
    end
    if (mismatches == 0) begin
      $display("sequential_read_detector_core verification clean");
    end else begin
      $display("sequential_read_detector_core verification failed");
    end
    $finish;
  end

endmodule
